// ===== design/point_segment_projection_top_assert.svh =====
// Assertion macros shared by the point segment projection RTL.
`ifndef POINT_SEGMENT_PROJECTION_TOP_ASSERT_SVH
`define POINT_SEGMENT_PROJECTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define PSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/psp_pkg.sv =====
// Types and constants shared by the point segment projection block.
`default_nettype none
package psp_pkg;

    // Default number of fractional bits in the projection parameter.
    localparam int FRACTION_BITS_DEF = 16;
    // Reset value of the degenerate length threshold.
    localparam logic [31:0] MIN_LEN_SQ_RESET = 32'd4295;
    // Widths of the exact intermediate values.
    localparam int DIFF_W = 33;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int LEN_W = 66;
    localparam int DOT_W = 67;
    localparam int OUT_FRAC_W = 17;

    // How the projection parameter is formed for one item.
    typedef enum logic [1:0] {
        MODE_DIV  = 2'd0,
        MODE_ZERO = 2'd1,
        MODE_ONE  = 2'd2
    } t_frac_mode;

    // Input beat.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_heading;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_heading;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] proj_heading;
        logic [OUT_FRAC_W-1:0] fraction;
        logic degenerate;
    } t_out_item;

    // Control and pose data that travels with an item down the pipeline.
    typedef struct packed {
        logic valid;
        t_frac_mode mode;
        logic degenerate;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sh;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dh;
    } t_carry;

endpackage
`default_nettype wire

// ===== design/psp_front.sv =====
// Front end: differences, products, squared length, dot product and clamp decision.
`default_nettype none
module psp_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire psp_pkg::t_in_item          i_item,
    input  wire logic [31:0]                i_min_len_sq,
    output psp_pkg::t_carry                 o_carry,
    output logic [psp_pkg::LEN_W-1:0]       o_rem,
    output logic [psp_pkg::LEN_W-1:0]       o_len
);
    import psp_pkg::*;
    `include "point_segment_projection_top_assert.svh"

    t_carry r_s1, r_s2, r_s3, r_s4;
    t_carry n_s1, n_s4;
    logic signed [DIFF_W-1:0] r_vx, r_vy;
    logic signed [PROD_W-1:0] r_pxx, r_pyy, r_pvx, r_pvy;
    logic [LEN_W-1:0]         r_len, r_len4, r_rem;
    logic signed [DOT_W-1:0]  r_dot;
    logic [LEN_W-1:0]         len_sum;
    logic signed [DOT_W-1:0]  dot_sum;
    logic                     dot_pos;
    logic                     dot_ge;
    logic                     degen;

    // Stage 1: exact 33-bit differences.
    always_comb begin
        n_s1 = '0;
        n_s1.valid = i_valid;
        n_s1.mode = MODE_ZERO;
        n_s1.sx = i_item.start_x;
        n_s1.sy = i_item.start_y;
        n_s1.sh = i_item.start_heading;
        n_s1.dx = {i_item.end_x[31], i_item.end_x} - {i_item.start_x[31], i_item.start_x};
        n_s1.dy = {i_item.end_y[31], i_item.end_y} - {i_item.start_y[31], i_item.start_y};
        n_s1.dh = {i_item.end_heading[31], i_item.end_heading}
                - {i_item.start_heading[31], i_item.start_heading};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.mode       <= n_s1.mode;
        r_s1.degenerate <= n_s1.degenerate;
        r_s1.sx <= n_s1.sx;
        r_s1.sy <= n_s1.sy;
        r_s1.sh <= n_s1.sh;
        r_s1.dx <= n_s1.dx;
        r_s1.dy <= n_s1.dy;
        r_s1.dh <= n_s1.dh;
        r_vx <= {i_item.point_x[31], i_item.point_x} - {i_item.start_x[31], i_item.start_x};
        r_vy <= {i_item.point_y[31], i_item.point_y} - {i_item.start_y[31], i_item.start_y};
    end

    // Stage 2: the four exact products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= r_s1.valid;
        end
        r_s2.mode       <= r_s1.mode;
        r_s2.degenerate <= r_s1.degenerate;
        r_s2.sx <= r_s1.sx;
        r_s2.sy <= r_s1.sy;
        r_s2.sh <= r_s1.sh;
        r_s2.dx <= r_s1.dx;
        r_s2.dy <= r_s1.dy;
        r_s2.dh <= r_s1.dh;
        r_pxx <= r_s1.dx * r_s1.dx;
        r_pyy <= r_s1.dy * r_s1.dy;
        r_pvx <= r_vx * r_s1.dx;
        r_pvy <= r_vy * r_s1.dy;
    end

    // Stage 3: squared length and signed dot product.
    assign len_sum = r_pxx[LEN_W-1:0] + r_pyy[LEN_W-1:0];
    assign dot_sum = {r_pvx[PROD_W-1], r_pvx} + {r_pvy[PROD_W-1], r_pvy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3.valid <= r_s2.valid;
        end
        r_s3.mode       <= r_s2.mode;
        r_s3.degenerate <= r_s2.degenerate;
        r_s3.sx <= r_s2.sx;
        r_s3.sy <= r_s2.sy;
        r_s3.sh <= r_s2.sh;
        r_s3.dx <= r_s2.dx;
        r_s3.dy <= r_s2.dy;
        r_s3.dh <= r_s2.dh;
        r_len <= len_sum;
        r_dot <= dot_sum;
    end

    // Stage 4: degenerate test and clamp decision.
    assign degen   = r_len < {{(LEN_W-32){1'b0}}, i_min_len_sq};
    assign dot_pos = !r_dot[DOT_W-1] && (r_dot != '0);
    assign dot_ge  = r_dot[LEN_W-1:0] >= r_len;

    always_comb begin
        n_s4 = r_s3;
        n_s4.degenerate = degen;
        if (degen || !dot_pos) begin
            n_s4.mode = MODE_ZERO;
        end else if (dot_ge) begin
            n_s4.mode = MODE_ONE;
        end else begin
            n_s4.mode = MODE_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else begin
            r_s4.valid <= n_s4.valid;
        end
        r_s4.mode       <= n_s4.mode;
        r_s4.degenerate <= n_s4.degenerate;
        r_s4.sx <= n_s4.sx;
        r_s4.sy <= n_s4.sy;
        r_s4.sh <= n_s4.sh;
        r_s4.dx <= n_s4.dx;
        r_s4.dy <= n_s4.dy;
        r_s4.dh <= n_s4.dh;
        r_rem  <= r_dot[LEN_W-1:0];
        r_len4 <= r_len;
    end

    assign o_carry = r_s4;
    assign o_rem   = r_rem;
    assign o_len   = r_len4;

    // The divider only sees a positive remainder below the length.
    `PSP_ASSERT_IMP(a_div_rem_below_len, i_clk, i_rst_n,
        r_s4.valid && (r_s4.mode == MODE_DIV), (r_rem < r_len4) && (r_rem != '0),
        "divider entered with a remainder out of range")
    // A degenerate segment always takes a zero fraction.
    `PSP_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n,
        r_s4.valid && r_s4.degenerate, r_s4.mode == MODE_ZERO,
        "degenerate segment without zero fraction")
    // Every accepted beat shows up in the first stage.
    `PSP_ASSERT_NXT(a_accept_s1, i_clk, i_rst_n, i_valid, r_s1.valid,
        "accepted beat lost at the first stage")

endmodule
`default_nettype wire

// ===== design/psp_div_cell.sv =====
// One restoring division cell: produces one quotient bit per item per cycle.
`default_nettype none
module psp_div_cell #(
    parameter int FRACTION_BITS = psp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire psp_pkg::t_carry            i_carry,
    input  wire logic [psp_pkg::LEN_W-1:0]  i_rem,
    input  wire logic [psp_pkg::LEN_W-1:0]  i_len,
    input  wire logic [FRACTION_BITS-1:0]   i_quo,
    output psp_pkg::t_carry                 o_carry,
    output logic [psp_pkg::LEN_W-1:0]       o_rem,
    output logic [psp_pkg::LEN_W-1:0]       o_len,
    output logic [FRACTION_BITS-1:0]        o_quo
);
    import psp_pkg::*;

    t_carry                  r_carry;
    logic [LEN_W-1:0]        r_rem, r_len;
    logic [FRACTION_BITS-1:0] r_quo;
    logic [LEN_W:0]          shifted;
    logic [LEN_W:0]          diff;
    logic                    q_bit;

    // Shift the remainder and try to subtract the length.
    assign shifted = {i_rem, 1'b0};
    assign diff    = shifted - {1'b0, i_len};
    assign q_bit   = shifted >= {1'b0, i_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
        end else begin
            r_carry.valid <= i_carry.valid;
        end
        r_carry.mode       <= i_carry.mode;
        r_carry.degenerate <= i_carry.degenerate;
        r_carry.sx <= i_carry.sx;
        r_carry.sy <= i_carry.sy;
        r_carry.sh <= i_carry.sh;
        r_carry.dx <= i_carry.dx;
        r_carry.dy <= i_carry.dy;
        r_carry.dh <= i_carry.dh;
        r_rem <= q_bit ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
        r_len <= i_len;
        r_quo <= {i_quo[FRACTION_BITS-2:0], q_bit};
    end

    assign o_carry = r_carry;
    assign o_rem   = r_rem;
    assign o_len   = r_len;
    assign o_quo   = r_quo;

endmodule
`default_nettype wire

// ===== design/psp_interp.sv =====
// Back end: selects t, interpolates the pose and forms the output beat.
`default_nettype none
module psp_interp #(
    parameter int FRACTION_BITS = psp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire psp_pkg::t_carry          i_carry,
    input  wire logic [FRACTION_BITS-1:0] i_quo,
    output logic                          o_valid,
    output psp_pkg::t_out_item            o_result
);
    import psp_pkg::*;

    localparam int T_W    = FRACTION_BITS + 1;
    localparam int PR_W   = T_W + 1 + DIFF_W;
    localparam int FRW_W  = T_W + OUT_FRAC_W - 1;

    logic [T_W-1:0]           t_sel;
    logic signed [T_W:0]      t_signed;
    logic [FRW_W-1:0]         frac_wide;
    logic [FRW_W-1:0]         frac_shift;
    logic                     r_valid1, r_valid2;
    logic signed [PR_W-1:0]   r_px, r_py, r_ph;
    logic signed [31:0]       r_sx, r_sy, r_sh;
    logic [OUT_FRAC_W-1:0]    r_frac;
    logic                     r_degen;
    t_out_item                r_out;

    // Final value of t from the clamp decision or the quotient.
    always_comb begin
        case (i_carry.mode)
            MODE_DIV:  t_sel = {1'b0, i_quo};
            MODE_ONE:  t_sel = {1'b1, {FRACTION_BITS{1'b0}}};
            MODE_ZERO: t_sel = '0;
            default:   t_sel = '0;
        endcase
    end

    assign t_signed   = {1'b0, t_sel};
    assign frac_wide  = {t_sel, {(OUT_FRAC_W-1){1'b0}}};
    assign frac_shift = frac_wide >> FRACTION_BITS;

    // Stage 1: t times each difference, exact and signed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= i_carry.valid;
        end
        r_px <= t_signed * i_carry.dx;
        r_py <= t_signed * i_carry.dy;
        r_ph <= t_signed * i_carry.dh;
        r_sx <= i_carry.sx;
        r_sy <= i_carry.sy;
        r_sh <= i_carry.sh;
        r_frac  <= frac_shift[OUT_FRAC_W-1:0];
        r_degen <= i_carry.degenerate;
    end

    // Stage 2: scale down with floor rounding and add the start value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
        end else begin
            r_valid2 <= r_valid1;
        end
        r_out.proj_x       <= r_sx + r_px[FRACTION_BITS+31:FRACTION_BITS];
        r_out.proj_y       <= r_sy + r_py[FRACTION_BITS+31:FRACTION_BITS];
        r_out.proj_heading <= r_sh + r_ph[FRACTION_BITS+31:FRACTION_BITS];
        r_out.fraction     <= r_frac;
        r_out.degenerate   <= r_degen;
    end

    assign o_valid  = r_valid2;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== design/point_segment_projection_top.sv =====
// An item passes the front end, the division chain and the interpolation stages in order.
// Throughput: one item per cycle while busy is low; the divider is a chain of FRACTION_BITS
// cells, one quotient bit per cell, so every stage takes a new beat each cycle.
// busy is high only in reset and until the ready flag is set after it; results cannot stall.
// Reset clears all valid flags and loads the length threshold with 4295.
`default_nettype none
module point_segment_projection_top #(
    parameter int FRACTION_BITS = psp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire psp_pkg::t_in_item   i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_data,
    output logic                     o_valid,
    output psp_pkg::t_out_item       o_result
);
    import psp_pkg::*;
    `include "point_segment_projection_top_assert.svh"

    logic              r_live;
    logic [31:0]       r_min_len_sq;
    t_carry            chain_carry [0:FRACTION_BITS];
    logic [LEN_W-1:0]  chain_rem   [0:FRACTION_BITS];
    logic [LEN_W-1:0]  chain_len   [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] chain_quo [0:FRACTION_BITS];

    // Ready flag and threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= 1'b0;
            r_min_len_sq <= MIN_LEN_SQ_RESET;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_we) begin
                r_min_len_sq <= i_cfg_data;
            end
        end
    end

    assign busy = !r_live;

    // Geometry front end.
    psp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start && !busy),
        .i_item       (i_item),
        .i_min_len_sq (r_min_len_sq),
        .o_carry      (chain_carry[0]),
        .o_rem        (chain_rem[0]),
        .o_len        (chain_len[0])
    );

    assign chain_quo[0] = '0;

    // Division chain, one cell per fraction bit.
    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_cell
        psp_div_cell #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_carry (chain_carry[g]),
            .i_rem   (chain_rem[g]),
            .i_len   (chain_len[g]),
            .i_quo   (chain_quo[g]),
            .o_carry (chain_carry[g+1]),
            .o_rem   (chain_rem[g+1]),
            .o_len   (chain_len[g+1]),
            .o_quo   (chain_quo[g+1])
        );
    end

    // Interpolation and output register.
    psp_interp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_carry  (chain_carry[FRACTION_BITS]),
        .i_quo    (chain_quo[FRACTION_BITS]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // A degenerate result reports a zero fraction.
    `PSP_ASSERT_IMP(a_degen_frac, i_clk, i_rst_n,
        o_valid && o_result.degenerate, o_result.fraction == '0,
        "degenerate result with nonzero fraction")
    // The fraction never exceeds one.
    `PSP_ASSERT_IMP(a_frac_max, i_clk, i_rst_n,
        o_valid, o_result.fraction <= {1'b1, {(OUT_FRAC_W-1){1'b0}}},
        "fraction above one")
    // A threshold write takes effect at the next edge.
    `PSP_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n,
        i_cfg_we, r_min_len_sq == $past(i_cfg_data),
        "threshold write lost")

endmodule
`default_nettype wire
